// ----- sv/rc5_pkg.sv -----
// Shared types, constants and helper functions for the five-digit radix converter.
// Holds the sequencer microcode table; used by every module of the block.
package rc5_pkg;

    localparam int DIGITS   = 5;
    localparam int SYM_W    = 8;
    localparam int RADIX_W  = 5;
    localparam int DIGIT_W  = 4;
    localparam int VALUE_W  = 20;

    // Working width of the value: whole bytes, never narrower than the reported value.
    localparam int RW_MIN   = ((DIGIT_W * DIGITS + 7) / 8) * 8;
    localparam int RW       = (RW_MIN < 24) ? 24 : RW_MIN;
    localparam int CHUNKS   = RW / 8;
    localparam int CNT_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CHK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    localparam logic [SYM_W-1:0] CH_0 = 8'h30;
    localparam logic [SYM_W-1:0] CH_9 = 8'h39;
    localparam logic [SYM_W-1:0] CH_A = 8'h41;
    localparam logic [SYM_W-1:0] CH_F = 8'h46;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
    localparam logic [RADIX_W-1:0] SRC_RESET = 5'd16;
    localparam logic [RADIX_W-1:0] TGT_RESET = 5'd10;
    localparam logic [4:0]         BAD_DIGIT = 5'd16;

    // Register indexes of the configuration port; register i sits at byte address 4*i.
    typedef enum logic {
        REG_SOURCE = 1'b0,
        REG_TARGET = 1'b1
    } reg_index_t;

    typedef logic [DIGITS-1:0][SYM_W-1:0] sym_vec_t;
    typedef logic [2:0] step_t;

    // Datapath operation selected by the current control word.
    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_LOAD  = 3'd1,
        OP_MAC   = 3'd2,
        OP_PREP  = 3'd3,
        OP_DIV   = 3'd4,
        OP_DIGIT = 3'd5,
        OP_OUT   = 3'd6
    } op_t;

    // Jump condition; when it holds the sequencer jumps, else it steps on.
    typedef enum logic [2:0] {
        C_NEVER       = 3'd0,
        C_ALWAYS      = 3'd1,
        C_IN_IDLE     = 3'd2,
        C_MORE_DIGITS = 3'd3,
        C_MORE_CHUNKS = 3'd4,
        C_OUT_FREE    = 3'd5
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic digit_last;
        logic chunk_last;
        logic out_free;
    } dp_status_t;

    localparam step_t ST_WAIT  = 3'd0;
    localparam step_t ST_ACC   = 3'd1;
    localparam step_t ST_PREP  = 3'd2;
    localparam step_t ST_DIV   = 3'd3;
    localparam step_t ST_DIGIT = 3'd4;
    localparam step_t ST_OUT   = 3'd5;
    localparam step_t ST_RETRY = 3'd6;

    // Microcode table, one control word per step.
    function automatic ctrl_word_t ucode(step_t s);
        ctrl_word_t cw;
        case (s)
            ST_WAIT:  cw = '{op: OP_LOAD,  cond: C_IN_IDLE,     target: ST_WAIT};
            ST_ACC:   cw = '{op: OP_MAC,   cond: C_MORE_DIGITS, target: ST_ACC};
            ST_PREP:  cw = '{op: OP_PREP,  cond: C_NEVER,       target: ST_WAIT};
            ST_DIV:   cw = '{op: OP_DIV,   cond: C_MORE_CHUNKS, target: ST_DIV};
            ST_DIGIT: cw = '{op: OP_DIGIT, cond: C_MORE_DIGITS, target: ST_DIV};
            ST_OUT:   cw = '{op: OP_OUT,   cond: C_OUT_FREE,    target: ST_WAIT};
            ST_RETRY: cw = '{op: OP_NOP,   cond: C_ALWAYS,      target: ST_OUT};
            default:  cw = '{op: OP_NOP,   cond: C_ALWAYS,      target: ST_WAIT};
        endcase
        return cw;
    endfunction

    function automatic logic [RADIX_W-1:0] clamp_radix(logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] v;
        if (r < RADIX_MIN)
            v = RADIX_MIN;
        else if (r > RADIX_MAX)
            v = RADIX_MAX;
        else
            v = r;
        return v;
    endfunction

    // Digit value of an ASCII symbol, or BAD_DIGIT for anything outside 0-9/A-F.
    function automatic logic [4:0] symbol_value(logic [SYM_W-1:0] ch);
        logic [4:0] v;
        case (ch) inside
            [CH_0:CH_9]: v = 5'(ch - CH_0);
            [CH_A:CH_F]: v = 5'(ch - CH_A) + 5'd10;
            default:     v = BAD_DIGIT;
        endcase
        return v;
    endfunction

    function automatic logic [SYM_W-1:0] value_symbol(logic [DIGIT_W-1:0] d);
        logic [SYM_W-1:0] c;
        if (d <= 4'd9)
            c = CH_0 + 8'(d);
        else
            c = CH_A + 8'(d) - 8'd10;
        return c;
    endfunction

endpackage

// ----- sv/rc5_sequencer.sv -----
// Microcode sequencer: step counter, control table lookup and conditional jumps.
// Depends on rc5_pkg for the control word, status struct and microcode table.
module rc5_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  rc5_pkg::dp_status_t status,
    output rc5_pkg::op_t        op
);
    import rc5_pkg::*;

    step_t      step_reg;
    step_t      step_next;
    ctrl_word_t cw;
    logic       take;

    always_comb
    begin
        cw = ucode(step_reg);
        case (cw.cond)
            C_NEVER:       take = 1'b0;
            C_ALWAYS:      take = 1'b1;
            C_IN_IDLE:     take = !status.in_valid;
            C_MORE_DIGITS: take = !status.digit_last;
            C_MORE_CHUNKS: take = !status.chunk_last;
            C_OUT_FREE:    take = status.out_free;
            default:       take = 1'b0;
        endcase
        step_next = take ? cw.target : step_reg + 3'd1;
    end

    assign op = cw.op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ST_WAIT;
        else
            step_reg <= step_next;
    end

endmodule

// ----- sv/rc5_datapath.sv -----
// Datapath of the radix converter: digit load, multiply-accumulate, byte-wide
// long division by the target radix, and the output register. Uses rc5_pkg.
module rc5_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rc5_pkg::op_t                  op,
    input  logic [rc5_pkg::RADIX_W-1:0]   source_radix,
    input  logic [rc5_pkg::RADIX_W-1:0]   target_radix,
    input  logic                          in_valid,
    input  rc5_pkg::sym_vec_t             sym_in,
    input  logic                          out_stall,
    output rc5_pkg::dp_status_t           status,
    output logic                          out_valid,
    output rc5_pkg::sym_vec_t             sym_out,
    output logic [rc5_pkg::VALUE_W-1:0]   value_out,
    output logic                          bad_out,
    output logic                          ovf_out
);
    import rc5_pkg::*;

    logic [DIGIT_W-1:0] dig_reg  [DIGITS];
    logic [DIGIT_W-1:0] odig_reg [DIGITS];
    logic               bad_reg;
    logic [RW-1:0]      acc_reg;
    logic [RW-1:0]      rest_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CHK_W-1:0]   chk_reg;

    logic               out_valid_reg;
    sym_vec_t           osym_reg;
    logic [VALUE_W-1:0] obin_reg;
    logic               obad_reg;
    logic               oovf_reg;

    logic [RADIX_W-1:0] sr;
    logic [RADIX_W-1:0] tr;
    logic               digit_last;
    logic               chunk_last;
    logic               out_free;
    logic               load;
    logic [RW+RADIX_W-1:0] prod;
    logic [RW-1:0]      acc_next;
    logic [7:0]         quo_bits;
    logic [DIGIT_W-1:0] rem_next;
    logic [4:0]         dval [DIGITS];
    logic               any_bad;

    assign sr         = clamp_radix(source_radix);
    assign tr         = clamp_radix(target_radix);
    assign digit_last = (cnt_reg == CNT_W'(DIGITS - 1));
    assign chunk_last = (chk_reg == CHK_W'(CHUNKS - 1));
    assign out_free   = !out_valid_reg || !out_stall;
    assign load       = (op == OP_LOAD) && in_valid;

    assign status = '{in_valid: in_valid, digit_last: digit_last,
                      chunk_last: chunk_last, out_free: out_free};

    always_comb
    begin
        any_bad = 1'b0;
        for (int k = 0; k < DIGITS; k++)
        begin
            dval[k] = symbol_value(sym_in[k]);
            any_bad = any_bad | dval[k][4];
        end
    end

    always_comb
    begin
        prod     = acc_reg * sr;
        acc_next = prod[RW-1:0] + RW'(dig_reg[0]);
    end

    // Eight restoring division steps on the top byte of the running quotient.
    always_comb
    begin
        logic [DIGIT_W-1:0] r;
        logic [4:0]         t;
        r        = rem_reg;
        quo_bits = '0;
        for (int b = 7; b >= 0; b--)
        begin
            t = {r, rest_reg[RW-8+b]};
            if (t >= tr)
            begin
                quo_bits[b] = 1'b1;
                r           = DIGIT_W'(t - tr);
            end
            else
            begin
                r = t[DIGIT_W-1:0];
            end
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            chk_reg <= '0;
        end
        else
        begin
            if (op == OP_MAC || op == OP_DIGIT)
                cnt_reg <= digit_last ? '0 : cnt_reg + 1'b1;
            if (op == OP_DIV)
                chk_reg <= chunk_last ? '0 : chk_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < DIGITS; k++)
                dig_reg[k] <= dval[k][DIGIT_W-1:0];
            bad_reg <= any_bad;
            acc_reg <= '0;
        end
        if (op == OP_MAC)
        begin
            acc_reg <= acc_next;
            for (int k = 0; k < DIGITS - 1; k++)
                dig_reg[k] <= dig_reg[k+1];
            dig_reg[DIGITS-1] <= '0;
        end
        if (op == OP_PREP)
        begin
            rest_reg <= acc_reg;
            rem_reg  <= '0;
        end
        if (op == OP_DIV)
        begin
            rest_reg <= {rest_reg[RW-9:0], quo_bits};
            rem_reg  <= rem_next;
        end
        if (op == OP_DIGIT)
        begin
            odig_reg[0] <= rem_reg;
            for (int k = 1; k < DIGITS; k++)
                odig_reg[k] <= odig_reg[k-1];
            rem_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (op == OP_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_OUT && out_free)
        begin
            for (int k = 0; k < DIGITS; k++)
                osym_reg[k] <= bad_reg ? CH_0 : value_symbol(odig_reg[k]);
            obin_reg <= bad_reg ? '0 : acc_reg[VALUE_W-1:0];
            obad_reg <= bad_reg;
            oovf_reg <= !bad_reg && (rest_reg != '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign sym_out   = osym_reg;
    assign value_out = obin_reg;
    assign bad_out   = obad_reg;
    assign ovf_out   = oovf_reg;

    a_bad_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && obad_reg) |-> (obin_reg == '0 && !oovf_reg))
        else $error("bad symbol result carries a value or overflow");

    a_counters_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_LOAD) |-> (cnt_reg == '0 && chk_reg == '0))
        else $error("digit or chunk counter not at zero between requests");

    a_load_to_mac: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (op == OP_MAC))
        else $error("accepted request not followed by accumulation");

    for (genvar g = 0; g < DIGITS; g++)
    begin : g_sym_chk
        a_sym_hex: assert property (@(posedge clk) disable iff (!rst_n)
            out_valid_reg |-> ((osym_reg[g] >= CH_0 && osym_reg[g] <= CH_9) ||
                               (osym_reg[g] >= CH_A && osym_reg[g] <= CH_F)))
            else $error("output symbol outside 0-9/A-F");
    end

endmodule

// ----- sv/radix_converter_5digit.sv -----
// Top level of the five-digit radix converter: APB register file, sequencer
// and datapath. Depends on rc5_pkg, rc5_sequencer and rc5_datapath.
//
// Usage: a request carries five ASCII symbols on in_sym_0 (most significant)
// through in_sym_4 and is taken at a rising edge with in_valid high and
// in_stall low. The block reads them in source_radix, builds the binary
// value, and writes it out again as five ASCII symbols in target_radix.
// One result follows every request, taken when out_valid is high and
// out_stall is low. A symbol outside 0-9/A-F sets bad_symbol and forces all
// output symbols to '0' with a zero value; a value that needs more than five
// target digits sets overflow and keeps the low five digits.
// Sequence: after the request is taken, the program runs five
// multiply-accumulate steps, one setup step, then four steps per output
// digit (three byte-wide division steps and one digit store), then the
// output load. A new request can be taken in the cycle after the result is
// loaded; no request is taken while the previous one is being converted.
// The result register frees the sequencer: the next request is accepted
// while a result still waits. If a new result is ready while the old
// one stalls, the sequencer loops on output and retry steps until it drains.
// Reset sets source_radix to 16 and target_radix to 10 and returns the
// sequencer to its wait step with no result pending.
module radix_converter_5digit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_sym_0,
    input  logic [7:0]  in_sym_1,
    input  logic [7:0]  in_sym_2,
    input  logic [7:0]  in_sym_3,
    input  logic [7:0]  in_sym_4,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_sym_0,
    output logic [7:0]  out_sym_1,
    output logic [7:0]  out_sym_2,
    output logic [7:0]  out_sym_3,
    output logic [7:0]  out_sym_4,
    output logic [19:0] binary_value,
    output logic        bad_symbol,
    output logic        overflow
);
    import rc5_pkg::*;

    logic [RADIX_W-1:0] src_radix_reg;
    logic [RADIX_W-1:0] tgt_radix_reg;
    logic               cfg_write;
    op_t                op;
    dp_status_t         status;
    sym_vec_t           sym_in;
    sym_vec_t           sym_out;

    // The register file: index in bit 2 of the byte address.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_radix_reg <= SRC_RESET;
            tgt_radix_reg <= TGT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_SOURCE: src_radix_reg <= pwdata[RADIX_W-1:0];
                REG_TARGET: tgt_radix_reg <= pwdata[RADIX_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SOURCE: prdata = {{(32-RADIX_W){1'b0}}, src_radix_reg};
            REG_TARGET: prdata = {{(32-RADIX_W){1'b0}}, tgt_radix_reg};
            default:    prdata = '0;
        endcase
    end

    // Requests are only taken in the wait step of the program.
    assign in_stall = (op != OP_LOAD);

    assign sym_in[0] = in_sym_0;
    assign sym_in[1] = in_sym_1;
    assign sym_in[2] = in_sym_2;
    assign sym_in[3] = in_sym_3;
    assign sym_in[4] = in_sym_4;

    rc5_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    rc5_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .source_radix (src_radix_reg),
        .target_radix (tgt_radix_reg),
        .in_valid     (in_valid),
        .sym_in       (sym_in),
        .out_stall    (out_stall),
        .status       (status),
        .out_valid    (out_valid),
        .sym_out      (sym_out),
        .value_out    (binary_value),
        .bad_out      (bad_symbol),
        .ovf_out      (overflow)
    );

    assign out_sym_0 = sym_out[0];
    assign out_sym_1 = sym_out[1];
    assign out_sym_2 = sym_out[2];
    assign out_sym_3 = sym_out[3];
    assign out_sym_4 = sym_out[4];

endmodule
